// ----- design/bpa_pkg.sv -----
// Package: constants, payload structs, state encoding and helpers for the buddy page allocator.
package bpa_pkg;

    localparam int NUM_FRAMES      = 256;
    localparam int FRAME_W         = 8;
    localparam int ORDER_W         = 4;
    localparam int MAX_ORDER_COUNT = 9;
    localparam int TOP_ORDER       = 8;
    localparam int PAGE_SHIFT      = 12;
    localparam int REQ_W           = 32;
    localparam int HDR_W           = 12;
    localparam int TOTAL_W         = REQ_W + 1;
    localparam int BIT_W           = 4;
    localparam int ROW_W           = 16;
    localparam int GRP_W           = FRAME_W - BIT_W;
    localparam int GROUPS          = NUM_FRAMES / ROW_W;
    localparam int BM_AW           = ORDER_W + GRP_W;
    localparam int STATUS_W        = 3;

    localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(16);

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd4;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [REQ_W-1:0]    request_bytes;
        logic [FRAME_W-1:0]  start_frame;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  block_frame;
        logic [ORDER_W-1:0]  block_order;
    } t_out_item;

    typedef struct packed {
        logic               in_use;
        logic [ORDER_W-1:0] order;
    } t_frame_ent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE,
        S_FIND,
        S_PICK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_FCHK,
        S_MERGE_RD,
        S_MERGE_WR,
        S_FINAL_RD,
        S_FINAL_WR,
        S_DONE
    } t_state;

    // index of the lowest set bit of a row, zero when empty
    function automatic logic [BIT_W-1:0] low_bit(input logic [ROW_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- design/buddy_page_allocator.sv -----
// Top level: buddy page allocator built around a free-head bitmap memory and a frame memory.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------
//  item     | in        | i_valid / o_stall    | i_item  (t_in_item)
//  result   | out       | o_valid / i_stall    | o_result (t_out_item)
//  config   | in        | i_cfg_we             | i_cfg_data (header_bytes)
//
// One transaction at a time. Allocate: size, find and pick, then one read-modify-write
// of a bitmap row per split level. Free: check the frame record, one read-modify-write
// per merge level, then the final insert. Errors end at the size, find or check step.
// Each path ends in a done state that loads the output register.
// Reset is synchronous; no clearing pass: frame entries carry valid bits and the
// single initial free block is covered by a boot flag. A stalled result holds the
// output register; the next item is taken as soon as the FSM is back in idle.
module buddy_page_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bpa_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output bpa_pkg::t_out_item o_result,
    input  logic              i_cfg_we,
    input  logic [11:0]       i_cfg_data
);
    import bpa_pkg::*;

    localparam logic [BM_AW-1:0] BOOT_ADDR = {ORDER_W'(TOP_ORDER), GRP_W'(0)};
    // only the top-order row of group 0 holds a free head after reset
    localparam logic [MAX_ORDER_COUNT-1:0][GROUPS-1:0] SUM_BOOT =
        (MAX_ORDER_COUNT * GROUPS)'(1) << (TOP_ORDER * GROUPS);

    // free-head bitmap: one row of ROW_W frames per (order, group)
    logic [ROW_W-1:0]   bm [2**BM_AW];
    logic [ROW_W-1:0]   r_bq;
    // per-frame allocation record
    t_frame_ent         fm [NUM_FRAMES];
    t_frame_ent         r_fq;
    logic [NUM_FRAMES-1:0] r_fvalid;
    logic               r_fq_valid;

    // row-nonzero summary, kept equal to "row has a free head"
    logic [MAX_ORDER_COUNT-1:0][GROUPS-1:0] r_sum;
    logic               r_boot;     // initial top-order head not yet in memory
    logic               r_rd_live;
    logic               r_rd_boot;

    t_state             r_state, n_state;
    logic [HDR_W-1:0]   r_hdr;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_zero, n_zero;
    logic [FRAME_W-1:0] r_f, n_f;
    logic [ORDER_W-1:0] r_k, n_k;
    logic [ORDER_W-1:0] r_need, n_need;
    logic [GRP_W-1:0]   r_grp, n_grp;
    logic [STATUS_W-1:0] r_st, n_st;
    logic [FRAME_W-1:0] r_rf, n_rf;
    logic [ORDER_W-1:0] r_ro, n_ro;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               accept;
    logic               out_free;
    logic [BM_AW-1:0]   bm_raddr, bm_waddr;
    logic               bm_we;
    logic [ROW_W-1:0]   bm_wdata;
    logic               fm_we;
    logic [FRAME_W-1:0] fm_waddr;
    t_frame_ent         fm_wdata;
    logic [ROW_W-1:0]   row_old;

    logic               fits;
    logic [ORDER_W-1:0] need_k;
    logic               found;
    logic [ORDER_W-1:0] find_k;
    logic [GRP_W-1:0]   find_grp;
    logic [FRAME_W-1:0] pick_f;
    logic [ORDER_W-1:0] split_k;
    logic [FRAME_W-1:0] split_f;
    logic [FRAME_W-1:0] split_wf;
    logic [FRAME_W-1:0] buddy_f;
    logic               buddy_free;
    logic               fq_in_use;
    logic [ORDER_W-1:0] fq_order;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign row_old  = r_rd_boot ? ROW_W'(1) : (r_rd_live ? r_bq : '0);

    // smallest order whose block covers the request plus header
    always_comb begin
        fits   = 1'b0;
        need_k = '0;
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if (r_total <= (TOTAL_W'(1) << (PAGE_SHIFT + k))) begin
                fits   = 1'b1;
                need_k = ORDER_W'(k);
            end
        end
    end

    // smallest order at or above need with any free head, then its lowest group
    always_comb begin
        found  = 1'b0;
        find_k = '0;
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if ((ORDER_W'(k) >= r_need) && (|r_sum[k])) begin
                found  = 1'b1;
                find_k = ORDER_W'(k);
            end
        end
        find_grp = GRP_W'(low_bit(ROW_W'(r_sum[find_k])));
    end

    assign pick_f     = {r_grp, low_bit(row_old)};
    assign split_k    = r_k - ORDER_W'(1);
    assign split_f    = r_f + (FRAME_W'(1) << split_k);
    assign split_wf   = r_f + (FRAME_W'(1) << r_k);
    assign buddy_f    = r_f ^ (FRAME_W'(1) << r_k);
    assign buddy_free = row_old[buddy_f[BIT_W-1:0]];
    assign fq_in_use  = r_fq_valid && r_fq.in_use;
    assign fq_order   = (r_fq.order > ORDER_W'(TOP_ORDER)) ? ORDER_W'(TOP_ORDER) : r_fq.order;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_item.mode == MODE_FREE) ? S_FCHK : S_SIZE;
                end
            end
            S_SIZE:     n_state = (r_zero || !fits) ? S_DONE : S_FIND;
            S_FIND:     n_state = found ? S_PICK : S_DONE;
            S_PICK:     n_state = (r_k > r_need) ? S_SPLIT_RD : S_DONE;
            S_SPLIT_RD: n_state = S_SPLIT_WR;
            S_SPLIT_WR: n_state = (r_k > r_need) ? S_SPLIT_RD : S_DONE;
            S_FCHK: begin
                if (!fq_in_use) begin
                    n_state = S_DONE;
                end else if (fq_order < ORDER_W'(TOP_ORDER)) begin
                    n_state = S_MERGE_RD;
                end else begin
                    n_state = S_FINAL_RD;
                end
            end
            S_MERGE_RD: n_state = S_MERGE_WR;
            S_MERGE_WR: begin
                if (buddy_free && (r_k + ORDER_W'(1) < ORDER_W'(TOP_ORDER))) begin
                    n_state = S_MERGE_RD;
                end else begin
                    n_state = S_FINAL_RD;
                end
            end
            S_FINAL_RD: n_state = S_FINAL_WR;
            S_FINAL_WR: n_state = S_DONE;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_total  = r_total;
        n_zero   = r_zero;
        n_f      = r_f;
        n_k      = r_k;
        n_need   = r_need;
        n_grp    = r_grp;
        n_st     = r_st;
        n_rf     = r_rf;
        n_ro     = r_ro;
        bm_raddr = '0;
        bm_waddr = '0;
        bm_we    = 1'b0;
        bm_wdata = '0;
        fm_we    = 1'b0;
        fm_waddr = r_f;
        fm_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_total = TOTAL_W'(i_item.request_bytes) + TOTAL_W'(r_hdr);
                    n_zero  = (i_item.request_bytes == '0);
                    n_f     = i_item.start_frame;
                end
            end
            S_SIZE: begin
                n_need = need_k;
                n_st   = r_zero ? ST_ZERO : ST_TOO_BIG;
                n_rf   = '0;
                n_ro   = '0;
            end
            S_FIND: begin
                bm_raddr = {find_k, find_grp};
                n_k      = find_k;
                n_grp    = find_grp;
                n_st     = ST_NO_BLOCK;
                n_rf     = '0;
                n_ro     = r_need;
            end
            S_PICK: begin
                // take the head out of its order and record the allocation
                bm_we    = 1'b1;
                bm_waddr = {r_k, r_grp};
                bm_wdata = row_old & ~(ROW_W'(1) << pick_f[BIT_W-1:0]);
                fm_we    = 1'b1;
                fm_waddr = pick_f;
                fm_wdata = '{in_use: 1'b1, order: r_need};
                n_f      = pick_f;
                n_st     = ST_OK;
                n_rf     = pick_f;
                n_ro     = r_need;
            end
            S_SPLIT_RD: begin
                bm_raddr = {split_k, split_f[FRAME_W-1:BIT_W]};
                n_k      = split_k;
            end
            S_SPLIT_WR: begin
                // upper half becomes a free head of this order
                bm_we    = 1'b1;
                bm_waddr = {r_k, split_wf[FRAME_W-1:BIT_W]};
                bm_wdata = row_old | (ROW_W'(1) << split_wf[BIT_W-1:0]);
            end
            S_FCHK: begin
                n_st = ST_BAD_FREE;
                n_rf = r_f;
                n_ro = '0;
                n_k  = fq_order;
                if (fq_in_use) begin
                    fm_we    = 1'b1;
                    fm_wdata = '{in_use: 1'b0, order: r_fq.order};
                end
            end
            S_MERGE_RD: begin
                bm_raddr = {r_k, buddy_f[FRAME_W-1:BIT_W]};
            end
            S_MERGE_WR: begin
                if (buddy_free) begin
                    bm_we    = 1'b1;
                    bm_waddr = {r_k, buddy_f[FRAME_W-1:BIT_W]};
                    bm_wdata = row_old & ~(ROW_W'(1) << buddy_f[BIT_W-1:0]);
                    n_f      = r_f & ~(FRAME_W'(1) << r_k);
                    n_k      = r_k + ORDER_W'(1);
                end
            end
            S_FINAL_RD: begin
                bm_raddr = {r_k, r_f[FRAME_W-1:BIT_W]};
            end
            S_FINAL_WR: begin
                bm_we    = 1'b1;
                bm_waddr = {r_k, r_f[FRAME_W-1:BIT_W]};
                bm_wdata = row_old | (ROW_W'(1) << r_f[BIT_W-1:0]);
                n_st     = ST_OK;
                n_rf     = r_f;
                n_ro     = r_k;
            end
            default: begin
            end
        endcase
    end

    // bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm[bm_waddr] <= bm_wdata;
        end
        r_bq <= bm[bm_raddr];
    end

    // frame memory, registered read at the incoming start frame
    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            fm[fm_waddr] <= fm_wdata;
        end
        r_fq <= fm[i_item.start_frame];
    end

    always_ff @(posedge i_clk) begin
        r_rd_live <= r_sum[bm_raddr[BM_AW-1:GRP_W]][bm_raddr[GRP_W-1:0]];
        r_total   <= n_total;
        r_zero    <= n_zero;
        r_f       <= n_f;
        r_k       <= n_k;
        r_need    <= n_need;
        r_grp     <= n_grp;
        r_st      <= n_st;
        r_rf      <= n_rf;
        r_ro      <= n_ro;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hdr       <= HDR_RESET;
            r_sum       <= SUM_BOOT;
            r_boot      <= 1'b1;
            r_rd_boot   <= 1'b0;
            r_fvalid    <= '0;
            r_fq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                r_hdr <= i_cfg_data;
            end
            r_rd_boot  <= r_boot && (bm_raddr == BOOT_ADDR);
            r_fq_valid <= r_fvalid[i_item.start_frame];
            if (bm_we) begin
                r_sum[bm_waddr[BM_AW-1:GRP_W]][bm_waddr[GRP_W-1:0]] <= |bm_wdata;
                if (bm_waddr == BOOT_ADDR) begin
                    r_boot <= 1'b0;
                end
            end
            if (fm_we) begin
                r_fvalid[fm_waddr] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= '{status: r_st, block_frame: r_rf, block_order: r_ro};
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/buddy_page_allocator_tb.sv -----
// Testbench: buddy_page_allocator checked transaction by transaction against an in-bench buddy predictor.
module buddy_page_allocator_tb;
    import bpa_pkg::*;

    localparam logic [3:0] MARK_ALLOC    = 4'(MAX_ORDER_COUNT);
    localparam logic [3:0] MARK_INTERIOR = 4'(MAX_ORDER_COUNT + 1);
    localparam int         IDLE_LIMIT    = 3000;   // cycles with no transaction at all
    localparam int         DRAIN_CYCLES  = 40;     // extra settling after the queues are empty
    localparam int         PHASE_ITEMS   = 40;
    localparam int         RANDOM_ITEMS  = 1800;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_item   i_item = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_item  o_result;
    logic       i_cfg_we = 1'b0;
    logic [11:0] i_cfg_data = '0;

    buddy_page_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the frame store: free-head order, MARK_ALLOC or MARK_INTERIOR per frame.
    logic [3:0]      frame_code [NUM_FRAMES];
    logic [3:0]      block_ord  [NUM_FRAMES];
    bit              frame_busy [NUM_FRAMES];
    logic [HDR_W-1:0] hdr_bytes;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        fail_count = 0;
    int        idle_cycles = 0;

    function automatic void paint_block(int f, int k, logic [3:0] head, logic [3:0] rest);
        for (int i = 0; i < (1 << k); i++) begin
            if (f + i < NUM_FRAMES) begin
                frame_code[f + i] = (i == 0) ? head : rest;
            end
        end
        if (f < NUM_FRAMES) begin
            block_ord[f] = 4'(k);
        end
    endfunction

    // Work out the result of one accepted transaction and advance the shadow pool.
    function automatic void predict_block(t_in_item it);
        t_out_item r;
        logic [32:0] total;
        int need, fk, f, k, b;
        bit fits, found, stop;
        r = '0;
        need = 0;
        fk = 0;
        f = 0;
        fits = 1'b0;
        found = 1'b0;
        stop = 1'b0;
        if (it.mode == MODE_ALLOC) begin
            if (it.request_bytes == '0) begin
                r.status = ST_ZERO;
            end else begin
                total = {1'b0, it.request_bytes} + 33'(hdr_bytes);
                for (k = 0; k <= TOP_ORDER; k++) begin
                    if (!fits && ((33'(1) << (PAGE_SHIFT + k)) >= total)) begin
                        need = k;
                        fits = 1'b1;
                    end
                end
                if (!fits) begin
                    r.status = ST_TOO_BIG;
                end else begin
                    // lowest-addressed free head of the smallest sufficient order
                    for (k = need; k <= TOP_ORDER; k++) begin
                        for (int i = 0; i < NUM_FRAMES; i++) begin
                            if (!found && frame_code[i] == 4'(k)) begin
                                f = i;
                                fk = k;
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found) begin
                        r.status = ST_NO_BLOCK;
                        r.block_order = ORDER_W'(need);
                    end else begin
                        for (k = fk; k > need; ) begin
                            k--;
                            paint_block(f + (1 << k), k, 4'(k), MARK_INTERIOR);
                        end
                        paint_block(f, need, MARK_ALLOC, MARK_ALLOC);
                        frame_busy[f] = 1'b1;
                        r.status = ST_OK;
                        r.block_frame = FRAME_W'(f);
                        r.block_order = ORDER_W'(need);
                    end
                end
            end
        end else begin
            f = it.start_frame;
            if (!frame_busy[f]) begin
                r.status = ST_BAD_FREE;
                r.block_frame = it.start_frame;
            end else begin
                k = block_ord[f];
                if (k > TOP_ORDER) begin
                    k = TOP_ORDER;
                end
                frame_busy[f] = 1'b0;
                while (k < TOP_ORDER && !stop) begin
                    b = f ^ (1 << k);
                    if (b >= NUM_FRAMES || frame_code[b] != 4'(k)) begin
                        stop = 1'b1;
                    end else begin
                        frame_code[b] = MARK_INTERIOR;
                        if (b < f) begin
                            f = b;
                        end
                        k++;
                    end
                end
                paint_block(f, k, 4'(k), MARK_INTERIOR);
                r.status = ST_OK;
                r.block_frame = FRAME_W'(f);
                r.block_order = ORDER_W'(k);
            end
        end
        expected_results.push_back(r);
    endfunction

    // Driver: bursts of random length, random gaps between them.
    int       burst_left = 4;
    int       gap_left = 0;
    t_in_item drive_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_block(drive_item);
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    drive_item = pending_items.pop_front();
                    i_item <= drive_item;
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: stretches of no stall, random stall, and long holds.
    int stall_mode = 0;
    int stall_span = 0;
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(5, 60);
        end
        stall_span--;
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_stall <= ($urandom_range(0, 9) != 0);
            end
        endcase
    end

    // Monitor: each result transaction against the oldest expectation.
    t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d frame=%0d order=%0d",
                         $time, o_result.status, o_result.block_frame, o_result.block_order);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.block_frame !== want.block_frame) begin
                    $display("%0t: block_frame expected %0d actual %0d",
                             $time, want.block_frame, o_result.block_frame);
                    fail_count++;
                end
                if (o_result.block_order !== want.block_order) begin
                    $display("%0t: block_order expected %0d actual %0d",
                             $time, want.block_order, o_result.block_order);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL buddy_page_allocator");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic mode, logic [31:0] bytes, logic [7:0] frame);
        t_in_item it;
        it.mode = mode;
        it.request_bytes = bytes;
        it.start_frame = frame;
        return it;
    endfunction

    // Blocks until every queued transaction is out and the block has settled.
    task automatic drain_block();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(logic [11:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hdr_bytes = v;
    endtask

    function automatic logic [31:0] pick_bytes();
        int o;
        int sel;
        sel = $urandom_range(0, 19);
        o = $urandom_range(0, 8);
        if (o > 4 && $urandom_range(0, 2) != 0) begin
            o = $urandom_range(0, 3);   // keep most blocks small so the pool churns
        end
        if (sel == 0) begin
            return 32'd0;
        end else if (sel == 1) begin
            return $urandom();          // almost always too large, exercises the high bits
        end else if (sel <= 4) begin
            // right at a page boundary after the header is added
            return 32'((4096 << o) - int'(hdr_bytes) + $urandom_range(0, 1));
        end
        return $urandom_range(1, 4096 << o);
    endfunction

    initial begin
        int cand[$];
        int produced;
        int phase;
        int idx;
        logic [11:0] hv;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_code[i] = MARK_INTERIOR;
            block_ord[i] = '0;
            frame_busy[i] = 1'b0;
        end
        frame_code[0] = 4'(TOP_ORDER);
        block_ord[0] = 4'(TOP_ORDER);
        hdr_bytes = HDR_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: whole pool, exhaustion, zero size, too large, bad frees, merges
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1048576 - 32'd16, 8'hFF));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'hFFFF_FFFF, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd255));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1048576 - 32'd15, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'hFFFF_FFFF, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd0, 8'hAA));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd5000, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd4080, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd3));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd1));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd2));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd524288 - 32'd16, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd524288 - 32'd16, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd128));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd0));
        drain_block();
        write_header(12'd4095);
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd4294963201, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd0));
        drain_block();
        write_header(12'd0);
        pending_items.push_back(make_item(MODE_ALLOC, 32'd4096, 8'd0));
        pending_items.push_back(make_item(MODE_ALLOC, 32'd1048576, 8'd0));
        pending_items.push_back(make_item(MODE_FREE, 32'd0, 8'd0));
        drain_block();

        // random phases, candidate frees taken from the settled shadow pool
        produced = 0;
        phase = 0;
        while (produced < RANDOM_ITEMS) begin
            if (phase % 4 == 3) begin
                case ($urandom_range(0, 3))
                    0: hv = 12'd0;
                    1: hv = 12'd4095;
                    2: hv = HDR_RESET;
                    default: hv = 12'($urandom_range(0, 4095));
                endcase
                write_header(hv);
            end
            cand.delete();
            for (int i = 0; i < NUM_FRAMES; i++) begin
                if (frame_busy[i]) begin
                    cand.push_back(i);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (cand.size() > 0 && $urandom_range(0, 99) < 45) begin
                    idx = $urandom_range(0, cand.size() - 1);
                    pending_items.push_back(make_item(MODE_FREE, $urandom(), 8'(cand[idx])));
                    cand.delete(idx);
                end else if ($urandom_range(0, 9) == 0) begin
                    // stray free: mostly bad, occasionally a real block
                    pending_items.push_back(make_item(MODE_FREE, $urandom(),
                                                      8'($urandom_range(0, 255))));
                end else begin
                    pending_items.push_back(make_item(MODE_ALLOC, pick_bytes(),
                                                      8'($urandom_range(0, 255))));
                end
            end
            produced += PHASE_ITEMS;
            phase++;
            drain_block();
        end

        if (fail_count == 0) begin
            $display("PASS buddy_page_allocator");
        end else begin
            $display("FAIL buddy_page_allocator");
        end
        $finish;
    end

endmodule
